// ===== rtl/lzid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzid_pkg
// shared types, constants and the distance table of the image decompressor
// ----------------------------------------------------------------------------
package lzid_pkg;

	localparam int DEF_HISTORY_DEPTH = 4096;
	localparam int DEF_MAX_ROW_WIDTH = 1024;
	localparam int DEF_LENGTH_BITS   = 24;

	localparam int ROW_W_BITS    = 11;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 1;
	localparam int RUN_BITS      = 11;
	localparam int DIST_BITS     = 14;
	localparam int IN_DATA_BITS  = 8;
	localparam int OUT_DATA_BITS = 16;

	localparam logic [ROW_W_BITS-1:0] ROW_WIDTH_RESET = 11'd640;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WIDTH    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_LENGTH = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		PH_FLAG    = 2'd0,
		PH_LITERAL = 2'd1,
		PH_LENHI   = 2'd2,
		PH_COPY    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_TRUNC    = 3'd1,
		ERR_OVERRUN  = 3'd2,
		ERR_DISTANCE = 3'd3,
		ERR_BUSY     = 3'd4
	} err_t;

	typedef struct packed {
		logic byte_valid;
		logic literal;
		logic copy;
		logic image_done;
		logic copy_pending;
		err_t error_code;
	} lzid_ctl_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       image_done;
		logic       copy_pending;
		err_t       error_code;
	} lzid_res_t;

	// back-reference distance for a flag nibble, zero for the literal nibble
	function automatic logic signed [DIST_BITS-1:0] distance(
		input logic [3:0]            nib,
		input logic [ROW_W_BITS-1:0] w
	);
		logic signed [DIST_BITS-1:0] ws;
		logic signed [DIST_BITS-1:0] d;
		ws = signed'({{(DIST_BITS-ROW_W_BITS){1'b0}}, w});
		case (nib)
			4'd1:    d = 14'sd1;
			4'd2:    d = ws;
			4'd3:    d = ws + 14'sd1;
			4'd4:    d = 14'sd2;
			4'd5:    d = ws - 14'sd1;
			4'd6:    d = ws * 14'sd2;
			4'd7:    d = 14'sd3;
			4'd8:    d = (ws + 14'sd1) * 14'sd2;
			4'd9:    d = ws + 14'sd2;
			4'd10:   d = ws * 14'sd2 + 14'sd1;
			4'd11:   d = ws * 14'sd2 - 14'sd1;
			4'd12:   d = (ws - 14'sd1) * 14'sd2;
			4'd13:   d = ws - 14'sd2;
			4'd14:   d = ws * 14'sd3;
			4'd15:   d = 14'sd4;
			default: d = 14'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/lz_image_decompressor_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_image_decompressor_2d
// lz decompressor with a row-width based distance table and history memory
// ----------------------------------------------------------------------------
//  channel  dir  handshake         contents
//  s_*      in   s_tvalid/tready   tdata data_byte, tlast last_byte, tuser kind
//  m_*      out  m_tvalid/tready   tdata out_byte, flags, error_code
//  cfg_*    in   cfg_we            cfg_index, cfg_data
//
//  one item per cycle while m_tready holds high; each transfer gives one result
//  history memory read is registered; a copy reading the byte still in the write
//  stage gets it by forwarding
//  a three-entry result queue keeps s_tready high while m_tready is low briefly
//  asynchronous reset clears control state; the history needs no clearing
// ----------------------------------------------------------------------------
module lz_image_decompressor_2d #(
	parameter int HISTORY_DEPTH = lzid_pkg::DEF_HISTORY_DEPTH,
	parameter int MAX_ROW_WIDTH = lzid_pkg::DEF_MAX_ROW_WIDTH,
	parameter int LENGTH_BITS   = lzid_pkg::DEF_LENGTH_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lzid_pkg::IN_DATA_BITS-1:0]    s_tdata,  // data_byte
	input  logic                                 s_tlast,
	input  logic                                 s_tuser,  // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_byte, byte_valid, image_done, copy_pending, error_code, zero pad
	output logic [lzid_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input  logic                                 cfg_we,
	input  logic [lzid_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lzid_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int AW         = $clog2(HISTORY_DEPTH);
	localparam int FIFO_DEPTH = 3;
	localparam int PW         = $clog2(FIFO_DEPTH);

	logic                 accept;
	lzid_pkg::lzid_ctl_t  ctl;
	logic [AW-1:0]        rd_addr, wr_addr;

	logic                 s1_valid_q;
	lzid_pkg::lzid_ctl_t  ctl_s1;
	logic [AW-1:0]        wr_addr_s1;
	logic [7:0]           lit_s1;
	logic                 fwd_s1;
	logic [7:0]           fwd_data_s1;
	logic [7:0]           rdata_q;
	logic [7:0]           byte_s1;
	logic                 fwd_hit;

	logic [7:0]           hist_mem [HISTORY_DEPTH];

	lzid_pkg::lzid_res_t  fifo_q [FIFO_DEPTH];
	lzid_pkg::lzid_res_t  res_in, res_out;
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [PW:0]          count_q;
	logic                 push, pop;

	assign accept = s_tvalid && s_tready;

	lzid_parser #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (s_tuser),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr)
	);

	// copy source still sitting in the write stage
	assign fwd_hit = s1_valid_q && ctl_s1.byte_valid && ctl.copy && (rd_addr == wr_addr_s1);

	always_comb begin
		if (!ctl_s1.byte_valid) begin
			byte_s1 = 8'd0;
		end else if (ctl_s1.literal) begin
			byte_s1 = lit_s1;
		end else if (fwd_s1) begin
			byte_s1 = fwd_data_s1;
		end else begin
			byte_s1 = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ctl.copy) begin
			rdata_q <= hist_mem[rd_addr];
		end
		if (s1_valid_q && ctl_s1.byte_valid) begin
			hist_mem[wr_addr_s1] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1      <= ctl;
			wr_addr_s1  <= wr_addr;
			lit_s1      <= s_tdata;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= byte_s1;
		end
	end

	assign res_in.out_byte     = byte_s1;
	assign res_in.byte_valid   = ctl_s1.byte_valid;
	assign res_in.image_done   = ctl_s1.image_done;
	assign res_in.copy_pending = ctl_s1.copy_pending;
	assign res_in.error_code   = ctl_s1.error_code;

	assign push     = s1_valid_q;
	assign m_tvalid = count_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = (count_q + (PW+1)'(s1_valid_q)) <= (PW+1)'(FIFO_DEPTH - 1);
	assign res_out  = fifo_q[rd_ptr_q];

	assign m_tdata = {2'b00, res_out.error_code, res_out.copy_pending, res_out.image_done,
		res_out.byte_valid, res_out.out_byte};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (int'(count_q) < FIFO_DEPTH || pop))
		else $error("result queue overflow");

	a_fwd_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fwd_hit) |=> (s1_valid_q && fwd_s1 && ctl_s1.copy))
		else $error("forwarded copy byte lost");

	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && ctl_s1.byte_valid) |-> (ctl_s1.literal != ctl_s1.copy))
		else $error("produced byte with no source");

endmodule

// ===== rtl/lzid_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzid_parser
// flag and length parsing, counters, error latch and history addressing
// ----------------------------------------------------------------------------
module lzid_parser #(
	parameter int HISTORY_DEPTH = lzid_pkg::DEF_HISTORY_DEPTH,
	parameter int MAX_ROW_WIDTH = lzid_pkg::DEF_MAX_ROW_WIDTH,
	parameter int LENGTH_BITS   = lzid_pkg::DEF_LENGTH_BITS,
	localparam int AW           = $clog2(HISTORY_DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 kind,
	input  logic [7:0]                           data_byte,
	input  logic                                 last_byte,
	input  logic                                 cfg_we,
	input  logic [lzid_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lzid_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output lzid_pkg::lzid_ctl_t                  ctl,
	output logic [AW-1:0]                        rd_addr,
	output logic [AW-1:0]                        wr_addr
);

	localparam int CDW   = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = ((LENGTH_BITS > lzid_pkg::RUN_BITS) ?
		LENGTH_BITS : lzid_pkg::RUN_BITS) + 1;
	localparam int RB    = lzid_pkg::RUN_BITS;

	logic [lzid_pkg::ROW_W_BITS-1:0] row_width_q;
	logic [LENGTH_BITS-1:0]          total_q;
	lzid_pkg::phase_t                phase_q, phase_d;
	lzid_pkg::err_t                  err_q, err_d;
	logic [RB-1:0]                   rr_q, rr_d;
	logic [CDW-1:0]                  cd_q, cd_d;
	logic [2:0]                      lh_q, lh_d;
	logic                            ended_q, ended_d;
	logic [LENGTH_BITS-1:0]          pc_q, pc_d, pc_inc;
	logic [AW-1:0]                   wp_q, wp_d;

	logic [lzid_pkg::ROW_W_BITS-1:0]         w_eff;
	logic signed [lzid_pkg::DIST_BITS-1:0]   dist_raw;
	logic                                    dist_ok;
	logic [CDW-1:0]                          new_cd;
	logic                                    emit, lit, cpy, ignored, do_start;
	logic [RB-1:0]                           sc_n;
	logic [CDW-1:0]                          sc_d;
	logic                                    done_now, done_inc;
	logic [AW:0]                             wp_x, cd_x, rd_full;

	assign w_eff = (int'(row_width_q) > MAX_ROW_WIDTH) ?
		lzid_pkg::ROW_W_BITS'(MAX_ROW_WIDTH) : row_width_q;
	assign dist_raw = lzid_pkg::distance(data_byte[7:4], w_eff);
	assign dist_ok  = !dist_raw[lzid_pkg::DIST_BITS-1] && (dist_raw != '0) &&
		(int'(dist_raw) <= HISTORY_DEPTH);
	assign new_cd   = dist_ok ? CDW'(dist_raw) : '0;

	assign pc_inc   = pc_q + 1'b1;
	assign done_now = pc_q >= total_q;
	assign done_inc = pc_inc >= total_q;

	always_comb begin : next_state
		phase_d  = phase_q;
		err_d    = err_q;
		rr_d     = rr_q;
		cd_d     = cd_q;
		lh_d     = lh_q;
		ended_d  = ended_q;
		pc_d     = pc_q;
		wp_d     = wp_q;
		emit     = 1'b0;
		lit      = 1'b0;
		cpy      = 1'b0;
		ignored  = 1'b0;
		do_start = 1'b0;
		sc_n     = '0;
		sc_d     = cd_q;
		if (err_q == lzid_pkg::ERR_NONE) begin
			if (kind == lzid_pkg::KIND_TICK) begin
				if (phase_q == lzid_pkg::PH_COPY) begin
					emit = 1'b1;
					cpy  = 1'b1;
					rr_d = rr_q - 1'b1;
					if (rr_q == RB'(1)) begin
						phase_d = lzid_pkg::PH_FLAG;
						if (ended_q && !done_inc) begin
							err_d = lzid_pkg::ERR_TRUNC;
						end
					end
				end
			end else if (phase_q == lzid_pkg::PH_COPY) begin
				err_d = lzid_pkg::ERR_BUSY;
			end else begin
				case (phase_q)
					lzid_pkg::PH_FLAG: begin
						if (done_now) begin
							ignored = 1'b1;
						end else if (data_byte[7:4] == 4'd0) begin
							if (data_byte != 8'd0 && last_byte) begin
								err_d = lzid_pkg::ERR_TRUNC;
							end else if ((SUM_W'(pc_q) + SUM_W'(data_byte)) >
									SUM_W'(total_q)) begin
								err_d = lzid_pkg::ERR_OVERRUN;
							end else begin
								rr_d    = RB'(data_byte);
								phase_d = (data_byte != 8'd0) ?
									lzid_pkg::PH_LITERAL : lzid_pkg::PH_FLAG;
							end
						end else begin
							cd_d = new_cd;
							if (data_byte[3]) begin
								if (last_byte) begin
									err_d = lzid_pkg::ERR_TRUNC;
								end else begin
									lh_d    = data_byte[2:0];
									phase_d = lzid_pkg::PH_LENHI;
								end
							end else begin
								do_start = 1'b1;
								sc_n     = RB'(data_byte[2:0]);
								sc_d     = new_cd;
							end
						end
					end
					lzid_pkg::PH_LITERAL: begin
						if (last_byte && rr_q > RB'(1)) begin
							err_d = lzid_pkg::ERR_TRUNC;
						end else begin
							emit = 1'b1;
							lit  = 1'b1;
							rr_d = rr_q - 1'b1;
							if (rr_q == RB'(1)) begin
								phase_d = lzid_pkg::PH_FLAG;
							end
						end
					end
					lzid_pkg::PH_LENHI: begin
						do_start = 1'b1;
						sc_n     = {lh_q, data_byte};
						sc_d     = cd_q;
					end
					default: begin
					end
				endcase
			end
		end
		if (do_start) begin
			if ((SUM_W'(pc_q) + SUM_W'(sc_n)) > SUM_W'(total_q)) begin
				err_d = lzid_pkg::ERR_OVERRUN;
			end else if (sc_n != '0 && (sc_d == '0 || 33'(sc_d) > 33'(pc_q))) begin
				err_d = lzid_pkg::ERR_DISTANCE;
			end else if (sc_n == '0) begin
				phase_d = lzid_pkg::PH_FLAG;
			end else begin
				rr_d    = sc_n;
				phase_d = lzid_pkg::PH_COPY;
			end
		end
		if (emit) begin
			pc_d = pc_inc;
			wp_d = (int'(wp_q) == HISTORY_DEPTH - 1) ? '0 : wp_q + 1'b1;
		end
		if (kind == lzid_pkg::KIND_BYTE && last_byte && err_q == lzid_pkg::ERR_NONE &&
				phase_q != lzid_pkg::PH_COPY && err_d == lzid_pkg::ERR_NONE && !ignored) begin
			ended_d = 1'b1;
			if (phase_d == lzid_pkg::PH_FLAG && !(emit ? done_inc : done_now)) begin
				err_d = lzid_pkg::ERR_TRUNC;
			end
		end
	end

	always_comb begin : outputs
		wp_x    = (AW+1)'(wp_q);
		cd_x    = (AW+1)'(cd_q);
		rd_full = (wp_x >= cd_x) ? (wp_x - cd_x) :
			(wp_x + (AW+1)'(HISTORY_DEPTH) - cd_x);
		rd_addr          = rd_full[AW-1:0];
		wr_addr          = wp_q;
		ctl.byte_valid   = emit;
		ctl.literal      = lit;
		ctl.copy         = cpy;
		ctl.image_done   = pc_d >= total_q;
		ctl.copy_pending = (err_d == lzid_pkg::ERR_NONE) && (phase_d == lzid_pkg::PH_COPY);
		ctl.error_code   = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= lzid_pkg::ROW_WIDTH_RESET;
			total_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lzid_pkg::CFG_ROW_WIDTH:    row_width_q <= cfg_data[lzid_pkg::ROW_W_BITS-1:0];
				lzid_pkg::CFG_TOTAL_LENGTH: total_q     <= LENGTH_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzid_pkg::PH_FLAG;
			err_q   <= lzid_pkg::ERR_NONE;
			rr_q    <= '0;
			cd_q    <= '0;
			lh_q    <= '0;
			ended_q <= 1'b0;
			pc_q    <= '0;
			wp_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			rr_q    <= rr_d;
			cd_q    <= cd_d;
			lh_q    <= lh_d;
			ended_q <= ended_d;
			pc_q    <= pc_d;
			wp_q    <= wp_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != lzid_pkg::ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("error latch changed after being set");

	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl.byte_valid) |=> (pc_q == $past(pc_inc)))
		else $error("produced count did not advance with a byte");

	a_copy_regs: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lzid_pkg::PH_COPY && err_q == lzid_pkg::ERR_NONE) |->
		(rr_q != '0 && cd_q != '0 && 33'(cd_q) <= 33'(pc_q)))
		else $error("copy pending with bad length or distance");

endmodule
